// File: rtl/core/mi_dir_pkg.sv
`timescale 1ns / 1ps

package mi_dir_pkg;

   // Fixed field widths
   localparam int BLOCK_W    = 10;
   localparam int NODE_W     = 4;
   localparam int LAT_W      = 10;
   localparam int DISP_W     = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LAT_W-1:0] MISS_LATENCY_RESET = LAT_W'(100);
   localparam logic [NODE_W-1:0] OWN_NODE_ID_RESET = '0;

   // Register select, taken from paddr[2] (word aligned registers)
   typedef enum logic {
      REG_MISS_LATENCY = 1'b0,
      REG_OWN_NODE_ID  = 1'b1
   } csr_reg_type;

   // Message kinds on the request channel
   typedef enum logic {
      ACT_GETM = 1'b0,
      ACT_DATA = 1'b1
   } action_type;

   // Coherence message kinds
   typedef enum logic {
      MSG_INV  = 1'b0,
      MSG_DATA = 1'b1
   } msg_kind_type;

   // Directory entry states; code 3 is unused
   typedef enum logic [1:0] {
      DIR_I  = 2'd0,
      DIR_M  = 2'd1,
      DIR_MM = 2'd2
   } dir_state_type;

   typedef enum logic [DISP_W-1:0] {
      DISP_NONE    = 3'd0,
      DISP_WAIT    = 3'd1,
      DISP_DONE    = 3'd2,
      DISP_REQUEUE = 3'd3,
      DISP_ERROR   = 3'd4
   } disp_type;

   // Engine sequencer
   typedef enum logic [1:0] {
      ENG_IDLE = 2'd0,
      ENG_SLOT = 2'd1,
      ENG_EXEC = 2'd2
   } eng_state_type;

   // One directory table word
   typedef struct packed {
      dir_state_type      state;
      logic [NODE_W-1:0]  owner;
      logic [NODE_W-1:0]  pending;
   } entry_type;

   // Configuration seen by the engine
   typedef struct packed {
      logic [LAT_W-1:0]  miss_latency;
      logic [NODE_W-1:0] own_node_id;
   } cfg_type;

endpackage

// File: rtl/core/mi_dir_csr.sv
`timescale 1ns / 1ps

module mi_dir_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [mi_dir_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mi_dir_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mi_dir_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                 pready,
   output mi_dir_pkg::cfg_type                  cfg
);

   logic [mi_dir_pkg::LAT_W-1:0]  miss_latency_ff;
   logic [mi_dir_pkg::NODE_W-1:0] own_node_id_ff;
   mi_dir_pkg::csr_reg_type       reg_sel;
   logic                          wr_xfer;

   assign reg_sel = mi_dir_pkg::csr_reg_type'(paddr[2]);
   assign wr_xfer = psel & penable & pwrite;
   assign pready  = 1'b1;

   // Register writes on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         miss_latency_ff <= mi_dir_pkg::MISS_LATENCY_RESET;
         own_node_id_ff  <= mi_dir_pkg::OWN_NODE_ID_RESET;
      end else if (wr_xfer) begin
         unique case (reg_sel)
            mi_dir_pkg::REG_MISS_LATENCY: begin
               miss_latency_ff <= pwdata[mi_dir_pkg::LAT_W-1:0];
            end
            mi_dir_pkg::REG_OWN_NODE_ID: begin
               own_node_id_ff <= pwdata[mi_dir_pkg::NODE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Read mux
   always_comb begin
      prdata = '0;
      unique case (reg_sel)
         mi_dir_pkg::REG_MISS_LATENCY: prdata = mi_dir_pkg::CSR_DATA_W'(miss_latency_ff);
         mi_dir_pkg::REG_OWN_NODE_ID:  prdata = mi_dir_pkg::CSR_DATA_W'(own_node_id_ff);
         default:                      prdata = '0;
      endcase
   end

   assign cfg.miss_latency = miss_latency_ff;
   assign cfg.own_node_id  = own_node_id_ff;

endmodule

// File: rtl/core/mi_dir_table.sv
`timescale 1ns / 1ps

module mi_dir_table #(
   parameter int ENTRIES = 1024,
   localparam int SLOT_W = $clog2(ENTRIES)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [SLOT_W-1:0]       rd_addr,
   output mi_dir_pkg::entry_type   rd_data,
   input  logic                    wr_en,
   input  logic [SLOT_W-1:0]       wr_addr,
   input  mi_dir_pkg::entry_type   wr_data,
   output logic                    clearing
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

   mi_dir_pkg::entry_type mem [ENTRIES];
   mi_dir_pkg::entry_type rd_data_ff;
   logic                  clr_active_ff;
   logic [SLOT_W-1:0]     clr_cnt_ff;
   logic                  mem_we;
   logic [SLOT_W-1:0]     mem_wa;
   mi_dir_pkg::entry_type mem_wd;
   mi_dir_pkg::entry_type clr_word;

   // Clearing sweep after reset, one entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else if (clr_active_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LAST_SLOT) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   assign clr_word.state   = mi_dir_pkg::DIR_I;
   assign clr_word.owner   = '0;
   assign clr_word.pending = '0;

   assign mem_we = clr_active_ff | wr_en;
   assign mem_wa = clr_active_ff ? clr_cnt_ff : wr_addr;
   assign mem_wd = clr_active_ff ? clr_word : wr_data;

   // Single write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_active_ff;

endmodule

// File: rtl/core/mi_dir_engine.sv
`timescale 1ns / 1ps

module mi_dir_engine #(
   parameter int ENTRIES = 1024,
   localparam int SLOT_W = $clog2(ENTRIES)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_valid,
   input  logic                                req_action,
   input  logic [mi_dir_pkg::BLOCK_W-1:0]      req_block_index,
   input  logic [mi_dir_pkg::NODE_W-1:0]       req_source_node,
   input  mi_dir_pkg::cfg_type                 cfg,
   input  logic                                clearing,
   output logic [SLOT_W-1:0]                   tbl_rd_addr,
   input  mi_dir_pkg::entry_type               tbl_rd_data,
   output logic                                tbl_wr_en,
   output logic [SLOT_W-1:0]                   tbl_wr_addr,
   output mi_dir_pkg::entry_type               tbl_wr_data,
   output logic                                rsp_valid,
   output logic [mi_dir_pkg::DISP_W-1:0]       rsp_disposition,
   output logic                                rsp_msg_valid,
   output logic                                rsp_msg_kind,
   output logic [mi_dir_pkg::NODE_W-1:0]       rsp_msg_target,
   output logic [mi_dir_pkg::BLOCK_W-1:0]      rsp_msg_block,
   output logic                                rsp_mem_data_valid,
   output logic [mi_dir_pkg::NODE_W-1:0]       rsp_mem_data_target,
   output logic [mi_dir_pkg::BLOCK_W-1:0]      rsp_mem_data_block,
   output logic [mi_dir_pkg::NODE_W-1:0]       rsp_sender_node
);

   localparam int BW       = mi_dir_pkg::BLOCK_W;
   localparam int NW       = mi_dir_pkg::NODE_W;
   // Slot reduction is needed only when the table is smaller than the index space
   localparam bit NEED_MOD = (ENTRIES < (2 ** BW));
   // Floor reciprocal, quotient estimate is exact or one low
   localparam int SH       = 2 * BW;
   localparam int RECIP    = (2 ** SH) / ENTRIES;
   localparam logic [SH-1:0] RECIP_C = SH'(RECIP);
   localparam logic [BW-1:0] ENT_C   = BW'(ENTRIES);

   mi_dir_pkg::eng_state_type state_ff, state_in;

   // Captured item
   logic                 valid_ff;
   mi_dir_pkg::action_type act_ff;
   logic [BW-1:0]        blk_ff;
   logic [NW-1:0]        src_ff;
   logic [BW-1:0]        q_ff;
   logic [SLOT_W-1:0]    slot_ff;

   // Miss timer
   logic                 miss_busy_ff, miss_busy_in;
   logic [mi_dir_pkg::LAT_W-1:0] miss_cnt_ff, miss_cnt_in;
   logic [BW-1:0]        miss_blk_ff, miss_blk_in;
   logic [NW-1:0]        miss_tgt_ff, miss_tgt_in;

   // Result registers
   logic                 rsp_valid_ff;
   mi_dir_pkg::disp_type disp_ff, disp_in;
   logic                 msg_valid_ff, msg_valid_in;
   mi_dir_pkg::msg_kind_type msg_kind_ff, msg_kind_in;
   logic [NW-1:0]        msg_target_ff, msg_target_in;
   logic [BW-1:0]        msg_block_ff, msg_block_in;
   logic                 mem_valid_ff, mem_valid_in;
   logic [NW-1:0]        mem_target_ff, mem_target_in;
   logic [BW-1:0]        mem_block_ff, mem_block_in;
   logic [NW-1:0]        sender_ff;

   logic                 accept;
   logic                 exec;
   logic [BW+SH-1:0]     recip_prod;
   logic [2*BW-1:0]      qe_prod;
   logic [BW-1:0]        rem_raw;
   logic [BW-1:0]        rem_fix;
   logic [SLOT_W-1:0]    direct_slot;
   logic [SLOT_W-1:0]    mod_slot;
   mi_dir_pkg::entry_type entry;
   logic                 upd_en;

   assign busy   = (state_ff != mi_dir_pkg::ENG_IDLE) | clearing;
   assign accept = start & ~busy;
   assign exec   = (state_ff == mi_dir_pkg::ENG_EXEC);

   // Slot reduction: quotient estimate at accept, remainder with one correction next cycle
   assign recip_prod  = (BW+SH)'(req_block_index) * (BW+SH)'(RECIP_C);
   assign qe_prod     = (2*BW)'(q_ff) * (2*BW)'(ENT_C);
   assign rem_raw     = blk_ff - qe_prod[BW-1:0];
   assign rem_fix     = (rem_raw >= ENT_C) ? (rem_raw - ENT_C) : rem_raw;
   assign mod_slot    = SLOT_W'(rem_fix);
   assign direct_slot = SLOT_W'(req_block_index);

   // Read is issued at accept, or after slot reduction
   assign tbl_rd_addr = (state_ff == mi_dir_pkg::ENG_SLOT) ? mod_slot : direct_slot;
   assign tbl_wr_addr = slot_ff;

   // Sequencer: write-back in EXEC finishes before the next read can be issued
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mi_dir_pkg::ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mi_dir_pkg::ENG_IDLE: begin
            if (accept) begin
               state_in = NEED_MOD ? mi_dir_pkg::ENG_SLOT : mi_dir_pkg::ENG_EXEC;
            end
         end
         mi_dir_pkg::ENG_SLOT: state_in = mi_dir_pkg::ENG_EXEC;
         mi_dir_pkg::ENG_EXEC: state_in = mi_dir_pkg::ENG_IDLE;
         default:              state_in = mi_dir_pkg::ENG_IDLE;
      endcase
   end

   // Item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         valid_ff <= req_valid;
         act_ff   <= mi_dir_pkg::action_type'(req_action);
         blk_ff   <= req_block_index;
         src_ff   <= req_source_node;
         q_ff     <= recip_prod[BW+SH-1:SH];
      end
      if (!exec) begin
         slot_ff <= tbl_rd_addr;
      end
   end

   // Protocol decision and miss timer
   always_comb begin
      entry         = tbl_rd_data;
      disp_in       = mi_dir_pkg::DISP_NONE;
      msg_valid_in  = 1'b0;
      msg_kind_in   = mi_dir_pkg::MSG_INV;
      msg_target_in = '0;
      msg_block_in  = '0;
      mem_valid_in  = 1'b0;
      mem_target_in = '0;
      mem_block_in  = '0;
      miss_busy_in  = miss_busy_ff;
      miss_cnt_in   = miss_cnt_ff;
      miss_blk_in   = miss_blk_ff;
      miss_tgt_in   = miss_tgt_ff;
      upd_en        = 1'b0;
      tbl_wr_data   = entry;

      if (valid_ff) begin
         if (miss_busy_ff) begin
            disp_in = mi_dir_pkg::DISP_WAIT;
         end else begin
            disp_in = mi_dir_pkg::DISP_ERROR;
            case (entry.state)
               mi_dir_pkg::DIR_I: begin
                  if (act_ff == mi_dir_pkg::ACT_GETM) begin
                     miss_busy_in      = 1'b1;
                     miss_cnt_in       = cfg.miss_latency;
                     miss_blk_in       = blk_ff;
                     miss_tgt_in       = src_ff;
                     tbl_wr_data.state = mi_dir_pkg::DIR_M;
                     tbl_wr_data.owner = src_ff;
                     upd_en            = 1'b1;
                     disp_in           = mi_dir_pkg::DISP_DONE;
                  end
               end
               mi_dir_pkg::DIR_M: begin
                  if (act_ff == mi_dir_pkg::ACT_GETM) begin
                     // No invalidate when the owner asks again
                     if (entry.owner != src_ff) begin
                        msg_valid_in  = 1'b1;
                        msg_kind_in   = mi_dir_pkg::MSG_INV;
                        msg_target_in = entry.owner;
                        msg_block_in  = blk_ff;
                     end
                     tbl_wr_data.state   = mi_dir_pkg::DIR_MM;
                     tbl_wr_data.pending = src_ff;
                     upd_en              = 1'b1;
                     disp_in             = mi_dir_pkg::DISP_DONE;
                  end
               end
               mi_dir_pkg::DIR_MM: begin
                  if (act_ff == mi_dir_pkg::ACT_DATA) begin
                     msg_valid_in      = 1'b1;
                     msg_kind_in       = mi_dir_pkg::MSG_DATA;
                     msg_target_in     = entry.pending;
                     msg_block_in      = blk_ff;
                     tbl_wr_data.state = mi_dir_pkg::DIR_M;
                     tbl_wr_data.owner = entry.pending;
                     upd_en            = 1'b1;
                     disp_in           = mi_dir_pkg::DISP_DONE;
                  end else begin
                     disp_in = mi_dir_pkg::DISP_REQUEUE;
                  end
               end
               default: begin
                  disp_in = mi_dir_pkg::DISP_ERROR;
               end
            endcase
         end
      end

      // Countdown runs once per tick, including the tick that started the miss
      if (miss_busy_in) begin
         if (miss_cnt_in == '0) begin
            mem_valid_in  = 1'b1;
            mem_target_in = miss_tgt_in;
            mem_block_in  = miss_blk_in;
            miss_busy_in  = 1'b0;
         end else begin
            miss_cnt_in = miss_cnt_in - 1'b1;
         end
      end
   end

   assign tbl_wr_en = exec & upd_en;

   // Miss timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         miss_busy_ff <= 1'b0;
         miss_cnt_ff  <= '0;
         miss_blk_ff  <= '0;
         miss_tgt_ff  <= '0;
      end else if (exec) begin
         miss_busy_ff <= miss_busy_in;
         miss_cnt_ff  <= miss_cnt_in;
         miss_blk_ff  <= miss_blk_in;
         miss_tgt_ff  <= miss_tgt_in;
      end
   end

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= exec;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (exec) begin
         disp_ff       <= disp_in;
         msg_valid_ff  <= msg_valid_in;
         msg_kind_ff   <= msg_kind_in;
         msg_target_ff <= msg_target_in;
         msg_block_ff  <= msg_block_in;
         mem_valid_ff  <= mem_valid_in;
         mem_target_ff <= mem_target_in;
         mem_block_ff  <= mem_block_in;
         sender_ff     <= cfg.own_node_id;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_disposition     = disp_ff;
   assign rsp_msg_valid       = msg_valid_ff;
   assign rsp_msg_kind        = msg_kind_ff;
   assign rsp_msg_target      = msg_target_ff;
   assign rsp_msg_block       = msg_block_ff;
   assign rsp_mem_data_valid  = mem_valid_ff;
   assign rsp_mem_data_target = mem_target_ff;
   assign rsp_mem_data_block  = mem_block_ff;
   assign rsp_sender_node     = sender_ff;

endmodule

// File: rtl/core/mi_directory_controller.sv
`timescale 1ns / 1ps

// MI directory controller. Each transfer on start/busy is one controller tick.
// When ENTRIES is 1024 or more, a tick reads the directory, then decides and
// writes back; when ENTRIES is smaller, the block index is first reduced
// modulo ENTRIES. The directory is one table with a single write port and a
// registered read, and busy stays high until its write-back is done. The
// result of every tick appears on the rsp_ ports for exactly one cycle,
// marked by rsp_valid, in the cycle after the write-back; the receiver
// cannot stall it and must take it then. After reset the block holds busy
// while the table is swept to the invalid state; register writes are taken
// during that time.
module mi_directory_controller #(
   parameter int ENTRIES = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_valid,
   input  logic                                 req_action,
   input  logic [mi_dir_pkg::BLOCK_W-1:0]       req_block_index,
   input  logic [mi_dir_pkg::NODE_W-1:0]        req_source_node,
   output logic                                 rsp_valid,
   output logic [mi_dir_pkg::DISP_W-1:0]        rsp_disposition,
   output logic                                 rsp_msg_valid,
   output logic                                 rsp_msg_kind,
   output logic [mi_dir_pkg::NODE_W-1:0]        rsp_msg_target,
   output logic [mi_dir_pkg::BLOCK_W-1:0]       rsp_msg_block,
   output logic                                 rsp_mem_data_valid,
   output logic [mi_dir_pkg::NODE_W-1:0]        rsp_mem_data_target,
   output logic [mi_dir_pkg::BLOCK_W-1:0]       rsp_mem_data_block,
   output logic [mi_dir_pkg::NODE_W-1:0]        rsp_sender_node,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [mi_dir_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mi_dir_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mi_dir_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                 pready
);

   localparam int SLOT_W = $clog2(ENTRIES);

   mi_dir_pkg::cfg_type   cfg;
   logic                  clearing;
   logic [SLOT_W-1:0]     tbl_rd_addr;
   mi_dir_pkg::entry_type tbl_rd_data;
   logic                  tbl_wr_en;
   logic [SLOT_W-1:0]     tbl_wr_addr;
   mi_dir_pkg::entry_type tbl_wr_data;

   // Configuration registers
   mi_dir_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Directory table
   mi_dir_table #(
      .ENTRIES (ENTRIES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (tbl_rd_addr),
      .rd_data  (tbl_rd_data),
      .wr_en    (tbl_wr_en),
      .wr_addr  (tbl_wr_addr),
      .wr_data  (tbl_wr_data),
      .clearing (clearing)
   );

   // Protocol engine
   mi_dir_engine #(
      .ENTRIES (ENTRIES)
   ) u_engine (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_valid           (req_valid),
      .req_action          (req_action),
      .req_block_index     (req_block_index),
      .req_source_node     (req_source_node),
      .cfg                 (cfg),
      .clearing            (clearing),
      .tbl_rd_addr         (tbl_rd_addr),
      .tbl_rd_data         (tbl_rd_data),
      .tbl_wr_en           (tbl_wr_en),
      .tbl_wr_addr         (tbl_wr_addr),
      .tbl_wr_data         (tbl_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_disposition     (rsp_disposition),
      .rsp_msg_valid       (rsp_msg_valid),
      .rsp_msg_kind        (rsp_msg_kind),
      .rsp_msg_target      (rsp_msg_target),
      .rsp_msg_block       (rsp_msg_block),
      .rsp_mem_data_valid  (rsp_mem_data_valid),
      .rsp_mem_data_target (rsp_mem_data_target),
      .rsp_mem_data_block  (rsp_mem_data_block),
      .rsp_sender_node     (rsp_sender_node)
   );

endmodule
